### rtl/evo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evo_pkg
// Shared constants and types of the elliptical vignette overlay.
// ----------------------------------------------------------------------------
package evo_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 16;

	// register indexes of the configuration port
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_INV_AXIS_X   = 3'd2;
	localparam logic [2:0] REG_INV_AXIS_Y   = 3'd3;
	localparam logic [2:0] REG_INV_CORNER   = 3'd4;
	localparam logic [2:0] REG_TINT_COLOR   = 3'd5;
	localparam logic [2:0] REG_SOFTNESS     = 3'd6;

	localparam int CFG_DATA_W = 32;

	// scaled offset magnitude saturates at 31 bits
	localparam int MAG_W   = 31;
	localparam logic [MAG_W-1:0] MAG_CAP = '1;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 1;
	localparam int ROOT_W  = 32;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 8;
	localparam int NUM_W   = 17;

	typedef struct packed {
		logic [31:0] argb;
		logic        keep;
	} side_t;

endpackage

### rtl/elliptical_vignette_overlay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elliptical_vignette_overlay
// Darkens (tints) pixels outside an ellipse centered in the frame.
// ----------------------------------------------------------------------------
// usage:
//  - s_* is the pixel input stream: tdata = {argb, y, x} from the lowest bit
//    x first, zero padded to whole bytes; one item per pixel
//  - m_* is the result stream: tdata = out_argb
//  - cfg_* writes one register per handshake (index, data); cfg_ready is
//    always high; write only while no pixel is in flight
//  - one item per cycle is sustained while the receiver takes every result;
//    the pipeline has 50 stages (32 square root steps, one per stage, and 8
//    divider steps for the blend)
//  - the whole pipeline advances together; when the receiver stalls with a
//    result waiting, every stage holds and s_tready drops, nothing is lost
//  - arst_n clears all valid bits and loads the default register values
//    (640x480 frame, 256-pixel semi-axes, unit corner radius, black tint,
//    zero softness)
// ----------------------------------------------------------------------------
module elliptical_vignette_overlay
	import evo_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// fields from bit 0: pixel_x, pixel_y, pixel_argb, zero padding
	input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// fields from bit 0: out_argb
	output logic [31:0] m_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DW  = COORD_BITS + 1;          // frame dimension width
	localparam int IW  = 8 + FRAC_BITS;           // reciprocal width
	localparam int PW  = COORD_BITS + IW;         // offset product width
	localparam int TW  = ROOT_W + 8;              // scaled radius width
	localparam int XPW = TW + 8;                  // radius times alpha
	// stage numbers
	localparam int ST_SUM  = 4;
	localparam int ST_ROOT = ST_SUM + SQRT_STEPS; // square root done
	localparam int ST_T    = ST_ROOT + 1;
	localparam int ST_X    = ST_T + 1;
	localparam int ST_O    = ST_X + 1;
	localparam int ST_D2   = ST_O + 1;
	localparam int ST_NUM  = ST_D2 + 1;
	localparam int ST_DIV  = ST_NUM + DIV_STEPS;
	localparam int NST     = ST_DIV + 1;

	// configuration registers
	logic [DW-1:0]   frame_width_q, frame_height_q;
	logic [IW-1:0]   inv_axis_x_q, inv_axis_y_q, inv_corner_q;
	logic [31:0]     tint_color_q;
	logic signed [8:0] softness_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DW'(640);
			frame_height_q <= DW'(480);
			inv_axis_x_q   <= IW'(1) << (FRAC_BITS - 8);
			inv_axis_y_q   <= IW'(1) << (FRAC_BITS - 8);
			inv_corner_q   <= IW'(1) << FRAC_BITS;
			tint_color_q   <= 32'hFF00_0000;
			softness_q     <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DW-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DW-1:0];
				REG_INV_AXIS_X:   inv_axis_x_q   <= cfg_data[IW-1:0];
				REG_INV_AXIS_Y:   inv_axis_y_q   <= cfg_data[IW-1:0];
				REG_INV_CORNER:   inv_corner_q   <= cfg_data[IW-1:0];
				REG_TINT_COLOR:   tint_color_q   <= cfg_data[31:0];
				REG_SOFTNESS:     softness_q     <= $signed(cfg_data[8:0]);
				default: ;
			endcase
		end
	end

	// global advance: the output register frees when taken
	logic           adv;
	logic [NST:1]   vld;
	side_t          side_s [1:NST];

	assign adv      = !vld[NST] || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[NST-1:1], s_tvalid};
		end
	end

	// input fields
	logic [COORD_BITS-1:0] in_x, in_y;
	logic [COORD_BITS-1:0] cx, cy;
	assign in_x = s_tdata[COORD_BITS-1:0];
	assign in_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign cx   = frame_width_q[DW-1:1];
	assign cy   = frame_height_q[DW-1:1];

	// stage 1: distance from the center
	logic [COORD_BITS-1:0] dx_s1, dy_s1;
	// stage 2: scaled and saturated magnitudes
	logic [MAG_W-1:0] mu_s2, mv_s2;
	logic [PW-1:0]    pu, pv;
	// stage 3: squares
	logic [SQ_W-1:0]  su_s3, sv_s3;
	// stage 4: sum of squares
	logic [SUM_W-1:0] sum_s4;

	assign pu = PW'(dx_s1) * PW'(inv_axis_x_q);
	assign pv = PW'(dy_s1) * PW'(inv_axis_y_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= (in_x >= cx) ? in_x - cx : cx - in_x;
			dy_s1  <= (in_y >= cy) ? in_y - cy : cy - in_y;
			mu_s2  <= (pu > PW'(MAG_CAP)) ? MAG_CAP : pu[MAG_W-1:0];
			mv_s2  <= (pv > PW'(MAG_CAP)) ? MAG_CAP : pv[MAG_W-1:0];
			su_s3  <= SQ_W'(mu_s2) * SQ_W'(mu_s2);
			sv_s3  <= SQ_W'(mv_s2) * SQ_W'(mv_s2);
			sum_s4 <= SUM_W'(su_s3) + SUM_W'(sv_s3);
		end
	end

	// side data travels down the whole pipeline
	logic inside_c;
	logic o_zero_c;
	assign inside_c = (SUM_W'(su_s3) + SUM_W'(sv_s3)) < (SUM_W'(1) << (2*FRAC_BITS));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= '{argb: s_tdata[2*COORD_BITS+31:2*COORD_BITS], keep: 1'b0};
			for (int i = 2; i <= NST; i++) begin
				if (i == ST_SUM)
					side_s[i] <= '{argb: side_s[i-1].argb, keep: inside_c};
				else if (i == ST_O)
					side_s[i] <= '{argb: side_s[i-1].argb,
						keep: side_s[i-1].keep || o_zero_c};
				else
					side_s[i] <= side_s[i-1];
			end
		end
	end

	// square root, one result bit per stage
	logic [SUM_W-1:0] rem_s [ST_SUM+1:ST_ROOT];
	logic [SUM_W-1:0] res_s [ST_SUM+1:ST_ROOT];

	genvar k;
	generate
		for (k = 0; k < SQRT_STEPS; k++) begin : g_root
			localparam logic [SUM_W:0] BIT = (SUM_W+1)'(1) << (2*(SQRT_STEPS-1-k));
			logic [SUM_W-1:0] rem_in, res_in;
			logic [SUM_W:0] trial;
			if (k == 0) begin : g_first
				assign rem_in = sum_s4;
				assign res_in = '0;
			end else begin : g_next
				assign rem_in = rem_s[ST_SUM+k];
				assign res_in = res_s[ST_SUM+k];
			end
			assign trial = {1'b0, res_in} + BIT;
			always_ff @(posedge clk) begin
				if (adv) begin
					if ({1'b0, rem_in} >= trial) begin
						rem_s[ST_SUM+k+1] <= rem_in - trial[SUM_W-1:0];
						res_s[ST_SUM+k+1] <= (res_in >> 1) + BIT[SUM_W-1:0];
					end else begin
						rem_s[ST_SUM+k+1] <= rem_in;
						res_s[ST_SUM+k+1] <= res_in >> 1;
					end
				end
			end
		end
	endgenerate

	// radius to opacity
	logic [ROOT_W+IW-1:0] tprod;
	logic [TW-1:0]        t_s37;
	logic [XPW-1:0]       xprod;
	logic [XPW-1:0]       xsh;
	logic [9:0]           x_s38;
	logic signed [11:0]   op;
	logic [7:0]           o_s39;

	assign tprod = (ROOT_W+IW)'(res_s[ST_ROOT][ROOT_W-1:0]) * (ROOT_W+IW)'(inv_corner_q);
	assign xprod = XPW'(t_s37) * XPW'(tint_color_q[31:24]);
	assign xsh   = xprod >> FRAC_BITS;
	assign op    = $signed({2'b00, x_s38}) - 12'(softness_q);
	assign o_zero_c = (op <= 12'sd0);

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s37 <= TW'(tprod >> FRAC_BITS);
			x_s38 <= (xsh > XPW'(1023)) ? 10'd1023 : xsh[9:0];
			if (op < 12'sd0)
				o_s39 <= 8'd0;
			else if (op > 12'sd255)
				o_s39 <= 8'd255;
			else
				o_s39 <= op[7:0];
		end
	end

	// blend: destination weight, then the three numerators
	logic [15:0] dprod;
	logic [16:0] dr;
	logic [7:0]  o_s40, d2_s40;
	logic [8:0]  oa_c;
	logic [31:0] argb_39;

	assign argb_39 = side_s[ST_O].argb;
	assign dprod   = 16'(argb_39[31:24]) * 16'(8'd255 - o_s39);
	assign dr      = 17'(dprod) + 17'd128;
	assign oa_c    = 9'(o_s40) + 9'(d2_s40);

	always_ff @(posedge clk) begin
		if (adv) begin
			o_s40  <= o_s39;
			d2_s40 <= 8'((dr + (dr >> 8)) >> 8);
		end
	end

	// restoring divider, one quotient bit per stage for each color channel
	logic [NUM_W-1:0] nrem_s [ST_NUM:ST_DIV][3];
	logic [7:0]       quo_s  [ST_NUM:ST_DIV][3];
	logic [8:0]       oa_s   [ST_NUM:ST_DIV];

	always_ff @(posedge clk) begin
		if (adv) begin
			oa_s[ST_NUM] <= oa_c;
			for (int c = 0; c < 3; c++) begin
				nrem_s[ST_NUM][c] <= NUM_W'(16'(tint_color_q[8*c +: 8]) * 16'(o_s40))
					+ NUM_W'(16'(side_s[ST_D2].argb[8*c +: 8]) * 16'(d2_s40))
					+ NUM_W'(oa_c >> 1);
				quo_s[ST_NUM][c]  <= '0;
			end
		end
	end

	genvar j;
	generate
		for (j = 0; j < DIV_STEPS; j++) begin : g_div
			localparam int SH = DIV_STEPS - 1 - j;
			logic [NUM_W-1:0] dsh;
			assign dsh = NUM_W'(oa_s[ST_NUM+j]) << SH;
			always_ff @(posedge clk) begin
				if (adv) begin
					oa_s[ST_NUM+j+1] <= oa_s[ST_NUM+j];
					for (int c = 0; c < 3; c++) begin
						if (nrem_s[ST_NUM+j][c] >= dsh) begin
							nrem_s[ST_NUM+j+1][c] <= nrem_s[ST_NUM+j][c] - dsh;
							quo_s[ST_NUM+j+1][c]  <= quo_s[ST_NUM+j][c] | (8'd1 << SH);
						end else begin
							nrem_s[ST_NUM+j+1][c] <= nrem_s[ST_NUM+j][c];
							quo_s[ST_NUM+j+1][c]  <= quo_s[ST_NUM+j][c];
						end
					end
				end
			end
		end
	endgenerate

	// output register
	logic [31:0] out_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (side_s[ST_DIV].keep)
				out_q <= side_s[ST_DIV].argb;
			else
				out_q <= {oa_s[ST_DIV][7:0], quo_s[ST_DIV][2], quo_s[ST_DIV][1],
					quo_s[ST_DIV][0]};
		end
	end

	assign m_tdata = out_q;

	// an accepted pixel always lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld[1])
		else $error("accepted pixel did not enter the pipeline");

	// a stall freezes every valid bit
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld))
		else $error("pipeline moved during a stall");

	// divider remainders end below the divisor for blended pixels
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld[ST_DIV] && !side_s[ST_DIV].keep) |->
		(nrem_s[ST_DIV][0] < NUM_W'(oa_s[ST_DIV])) &&
		(nrem_s[ST_DIV][1] < NUM_W'(oa_s[ST_DIV])) &&
		(nrem_s[ST_DIV][2] < NUM_W'(oa_s[ST_DIV])))
		else $error("blend divider remainder out of range");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elliptical vignette overlay: a directed table
// of pixels then random pixels under several register settings, each result
// compared with a typed value or in-bench model of ellipse and tint blend.
// ----------------------------------------------------------------------------
module tb_top
	import evo_pkg::*;
();

	localparam int CB = 12;
	localparam int FB = 16;
	localparam int SW = ((2*CB+32+7)/8)*8;
	localparam int LATENCY = 50;
	localparam longint CYCLE_LIMIT = 400000;
	// index with no register behind it
	localparam logic [2:0] REG_NONE = 3'd7;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// fields from bit 0: pixel_x, pixel_y, pixel_argb, zero padding
	logic [SW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// fields from bit 0: out_argb
	logic [31:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	elliptical_vignette_overlay #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// register shadow
	logic [12:0] width_q, height_q;
	logic [23:0] inv_x_q, inv_y_q, inv_corner_q;
	logic [31:0] tint_q;
	logic signed [8:0] soft_q;

	typedef struct {
		logic [11:0] px;
		logic [11:0] py;
		logic [31:0] argb;
		logic        known;  // expected value typed in
		logic [31:0] want;
	} pixel_row_t;

	logic [31:0] blended_q[$];
	int errors = 0;
	longint cycle = 0;
	int accepted;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] offset_mag(logic [11:0] c, logic [12:0] dim,
			logic [23:0] inv);
		logic [63:0] mid, d, m;
		mid = dim >> 1;
		d = (c >= mid) ? (c - mid) : (mid - c);
		m = d * inv;
		return (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : m;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] s);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] vignette_pixel(logic [11:0] px, logic [11:0] py,
			logic [31:0] src);
		logic [63:0] u, v, s, r, t, x;
		longint op;
		int o, d2, oa, tc, dc, c, prod;
		logic [31:0] res;
		u = offset_mag(px, width_q, inv_x_q);
		v = offset_mag(py, height_q, inv_y_q);
		s = u * u + v * v;
		if (s < (64'd1 << (2*FB))) return src;
		r = root_floor(s);
		t = (r * inv_corner_q) >> FB;
		x = (t * tint_q[31:24]) >> FB;
		if (x > 1023) x = 1023;
		op = longint'(x) - longint'(soft_q);
		if (op < 0) op = 0;
		if (op > 255) op = 255;
		o = int'(op);
		if (o == 0) return src;
		// alpha of the pixel behind the tint, divided by 255 with rounding
		prod = src[31:24] * (255 - o);
		d2 = (prod + 128 + ((prod + 128) >> 8)) >> 8;
		oa = o + d2;
		res = 0;
		res[31:24] = oa[7:0];
		for (int sh = 0; sh < 24; sh += 8) begin
			tc = (tint_q >> sh) & 8'hFF;
			dc = (src >> sh) & 8'hFF;
			c = (tc * o + dc * d2 + (oa >> 1)) / oa;
			if (c > 255) c = 255;
			res |= c << sh;
		end
		return res;
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (blended_q.size() == 0) begin
				$error("unexpected item out_argb=%h", m_tdata);
				errors++;
			end else begin
				logic [31:0] w;
				w = blended_q.pop_front();
				if (m_tdata !== w) begin
					$error("out_argb expected %h actual %h", w, m_tdata);
					errors++;
				end
			end
		end
	end

	// receiver stalls
	initial begin
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 1)) gap = 0;
			repeat (gap) begin
				m_tready <= 0;
				@(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		@(posedge clk);
		case (idx)
			REG_FRAME_WIDTH:  width_q = val[12:0];
			REG_FRAME_HEIGHT: height_q = val[12:0];
			REG_INV_AXIS_X:   inv_x_q = val[23:0];
			REG_INV_AXIS_Y:   inv_y_q = val[23:0];
			REG_INV_CORNER:   inv_corner_q = val[23:0];
			REG_TINT_COLOR:   tint_q = val;
			REG_SOFTNESS:     soft_q = val[8:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (blended_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic send_pixel(pixel_row_t p, bit use_gap);
		int gap;
		gap = use_gap ? $urandom_range(0, 11) : 0;
		if (use_gap && $urandom_range(0, 2) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= SW'({p.argb, p.py, p.px});
		blended_q.push_back(p.known ? p.want : vignette_pixel(p.px, p.py, p.argb));
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		accepted++;
	endtask

	task automatic random_pixels(int n, int spread);
		pixel_row_t p;
		for (int i = 0; i < n; i++) begin
			// mostly coordinates near the frame, some anywhere
			if ($urandom_range(0, 3) == 0) begin
				p.px = $urandom;
				p.py = $urandom;
			end else begin
				p.px = $urandom_range(0, spread);
				p.py = $urandom_range(0, spread);
			end
			p.argb = $urandom;
			p.known = 0;
			p.want = 0;
			send_pixel(p, 1);
		end
		s_tvalid <= 0;
	endtask

	// directed table
	pixel_row_t directed[10] = '{
		// center of the default frame is inside
		'{12'd320, 12'd240, 32'h1234_5678, 1'b1, 32'h1234_5678},
		// far corner with full black tint, opaque pixel
		'{12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{12'hFFF, 12'hFFF, 32'h0000_0000, 1'b0, 32'h0},
		'{12'hFFF, 12'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{12'd0, 12'hFFF, 32'h80A0_B0C0, 1'b0, 32'h0},
		'{12'd575, 12'd240, 32'h7F7F_7F7F, 1'b0, 32'h0},
		'{12'd576, 12'd240, 32'hFF00_FF00, 1'b0, 32'h0},
		'{12'd320, 12'd495, 32'h00FF_00FF, 1'b0, 32'h0},
		'{12'd320, 12'd496, 32'hAAAA_5555, 1'b0, 32'h0},
		'{12'd319, 12'd241, 32'h5555_AAAA, 1'b0, 32'h0}
	};

	initial begin
		pixel_row_t p;
		accepted = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		width_q = 640; height_q = 480;
		inv_x_q = 256; inv_y_q = 256; inv_corner_q = 65536;
		tint_q = 32'hFF00_0000; soft_q = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (directed[i]) send_pixel(directed[i], i % 2);
		s_tvalid <= 0;
		wait_drained();

		// small frame, tight ellipse, colored tint, heavy softness
		write_reg(REG_FRAME_WIDTH, 64);
		write_reg(REG_FRAME_HEIGHT, 48);
		write_reg(REG_INV_AXIS_X, 24'h0_0800);
		write_reg(REG_INV_AXIS_Y, 24'h0_0AAA);
		write_reg(REG_INV_CORNER, 24'h0_C000);
		write_reg(REG_TINT_COLOR, 32'hC030_6090);
		write_reg(REG_SOFTNESS, 9'h181);   // -127
		random_pixels(100, 80);
		// sender holds off until every result is back
		wait_drained();

		// extremes: zero-width frame, huge and zero reciprocals, max softness
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		write_reg(REG_INV_AXIS_X, 24'hFF_FFFF);
		write_reg(REG_INV_AXIS_Y, 24'h00_0000);
		write_reg(REG_INV_CORNER, 24'hFF_FFFF);
		write_reg(REG_TINT_COLOR, 32'hFFFF_FFFF);
		write_reg(REG_SOFTNESS, 9'h0FF);   // +255
		write_reg(REG_NONE, 32'hDEAD_BEEF); // unmapped index, ignored
		random_pixels(90, 4095);
		wait_drained();

		write_reg(REG_SOFTNESS, 9'h101);   // -255
		write_reg(REG_INV_CORNER, 24'h00_0000);
		write_reg(REG_FRAME_WIDTH, 4096);
		write_reg(REG_FRAME_HEIGHT, 1);
		write_reg(REG_INV_AXIS_Y, 24'h00_0100);
		random_pixels(60, 4095);
		wait_drained();

		// moderate settings, random registers
		for (int k = 0; k < 5; k++) begin
			write_reg(REG_FRAME_WIDTH, $urandom_range(1, 4096));
			write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 4096));
			write_reg(REG_INV_AXIS_X, $urandom_range(32, 4096));
			write_reg(REG_INV_AXIS_Y, $urandom_range(32, 4096));
			write_reg(REG_INV_CORNER, $urandom);
			write_reg(REG_TINT_COLOR, $urandom);
			write_reg(REG_SOFTNESS, $urandom);
			random_pixels(50, 4095);
			wait_drained();
		end

		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/evo_pkg.sv
rtl/elliptical_vignette_overlay.sv
verif/tb_top.sv
